// ===== hw/rtl/epcw_pkg.sv =====
// ----------------------------------------------------------------------------
// epcw_pkg
// Shared types, command codes and helper functions of the e-paper command
// and RAM window writer.
// ----------------------------------------------------------------------------
package epcw_pkg;

  localparam int AXIS_W      = 10;
  localparam int BUSY_W      = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_TDATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_REFRESH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_REFRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_REFRESH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_REFRESH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_STEP   = 3'd4;

  // Configuration reset values (microseconds)
  localparam logic [BUSY_W-1:0] FULL_REFRESH_RST = 24'd1800000;
  localparam logic [BUSY_W-1:0] FAST_REFRESH_RST = 24'd500000;
  localparam logic [BUSY_W-1:0] HALF_REFRESH_RST = 24'd1800000;
  localparam logic [BUSY_W-1:0] GRAY_REFRESH_RST = 24'd600000;
  localparam logic [BUSY_W-1:0] POWER_STEP_RST   = 24'd20000;

  // Command codes
  localparam logic [7:0] CMD_DRIVER_OUTPUT  = 8'h01;
  localparam logic [7:0] CMD_GATE_VOLTAGE   = 8'h03;
  localparam logic [7:0] CMD_SOURCE_VOLTAGE = 8'h04;
  localparam logic [7:0] CMD_BOOSTER        = 8'h0C;
  localparam logic [7:0] CMD_DEEP_SLEEP     = 8'h10;
  localparam logic [7:0] CMD_DATA_ENTRY     = 8'h11;
  localparam logic [7:0] CMD_SW_RESET       = 8'h12;
  localparam logic [7:0] CMD_TEMP_SENSOR    = 8'h18;
  localparam logic [7:0] CMD_TEMP_WRITE     = 8'h1A;
  localparam logic [7:0] CMD_MASTER_ACT     = 8'h20;
  localparam logic [7:0] CMD_UPDATE_CTRL1   = 8'h21;
  localparam logic [7:0] CMD_UPDATE_CTRL2   = 8'h22;
  localparam logic [7:0] CMD_WRITE_BW       = 8'h24;
  localparam logic [7:0] CMD_WRITE_RED      = 8'h26;
  localparam logic [7:0] CMD_VCOM           = 8'h2C;
  localparam logic [7:0] CMD_WRITE_LUT      = 8'h32;
  localparam logic [7:0] CMD_BORDER         = 8'h3C;
  localparam logic [7:0] CMD_RAM_X_RANGE    = 8'h44;
  localparam logic [7:0] CMD_RAM_Y_RANGE    = 8'h45;
  localparam logic [7:0] CMD_FILL_BW        = 8'h46;
  localparam logic [7:0] CMD_FILL_RED       = 8'h47;
  localparam logic [7:0] CMD_RAM_X_COUNT    = 8'h4E;
  localparam logic [7:0] CMD_RAM_Y_COUNT    = 8'h4F;
  localparam logic [7:0] CMD_AUX_A          = 8'h70;
  localparam logic [7:0] CMD_AUX_B          = 8'h71;
  localparam logic [7:0] CMD_AUX_C          = 8'hA2;

  // Update control codes
  localparam logic [7:0] UPD_FULL      = 8'hF7;
  localparam logic [7:0] UPD_FAST_A    = 8'hFC;
  localparam logic [7:0] UPD_FAST_B    = 8'hC7;
  localparam logic [7:0] UPD_FAST_C    = 8'hFF;
  localparam logic [7:0] UPD_FAST_D    = 8'h1C;
  localparam logic [7:0] UPD_FAST_E    = 8'hDC;
  localparam logic [7:0] UPD_HALF      = 8'hD7;
  localparam logic [7:0] UPD_GRAY      = 8'hCC;
  localparam logic [7:0] UPD_POWER_ON  = 8'hC0;
  localparam logic [7:0] UPD_POWER_OFF = 8'h03;
  localparam int         UPD_DISPLAY_BIT   = 2;
  localparam int         UPD_LUT_CLEAR_BIT = 5;

  localparam logic [2:0] ENTRY_MODE_RST = 3'd3;
  localparam logic [2:0] ARG_COUNT_MAX  = 3'd7;

  typedef enum logic [1:0] {
    MOP_NONE  = 2'd0,
    MOP_WRITE = 2'd1,
    MOP_FILL  = 2'd2
  } mem_op_t;

  typedef enum logic [2:0] {
    RM_NONE  = 3'd0,
    RM_FULL  = 3'd1,
    RM_FAST  = 3'd2,
    RM_HALF  = 3'd3,
    RM_GRAY  = 3'd4,
    RM_OTHER = 3'd5
  } refresh_mode_t;

  typedef struct packed {
    logic [BUSY_W-1:0] full_us;
    logic [BUSY_W-1:0] fast_us;
    logic [BUSY_W-1:0] half_us;
    logic [BUSY_W-1:0] gray_us;
    logic [BUSY_W-1:0] step_us;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] value;
  } item_t;

  // Last member sits in the lowest bits
  typedef struct packed {
    logic              gate_reversed;
    logic              sleeping;
    logic              unknown_command;
    logic [BUSY_W-1:0] busy_us;
    logic              busy_start;
    refresh_mode_t     refresh_mode;
    logic [7:0]        data;
    logic [6:0]        column;
    logic [8:0]        row;
    logic              plane;
    mem_op_t           memory_op;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  function automatic logic known_code(input logic [7:0] b);
    logic k;
    unique case (b)
      CMD_DRIVER_OUTPUT, CMD_GATE_VOLTAGE, CMD_SOURCE_VOLTAGE, CMD_BOOSTER,
      CMD_DEEP_SLEEP, CMD_DATA_ENTRY, CMD_SW_RESET, CMD_TEMP_SENSOR,
      CMD_TEMP_WRITE, CMD_MASTER_ACT, CMD_UPDATE_CTRL1, CMD_UPDATE_CTRL2,
      CMD_WRITE_BW, CMD_WRITE_RED, CMD_VCOM, CMD_WRITE_LUT, CMD_BORDER,
      CMD_RAM_X_RANGE, CMD_RAM_Y_RANGE, CMD_FILL_BW, CMD_FILL_RED,
      CMD_RAM_X_COUNT, CMD_RAM_Y_COUNT, CMD_AUX_A, CMD_AUX_B,
      CMD_AUX_C: k = 1'b1;
      default:   k = 1'b0;
    endcase
    return k;
  endfunction

  // Refresh mode of an update control code; power-only codes give none
  function automatic refresh_mode_t mode_lookup(input logic [7:0] v);
    refresh_mode_t m;
    unique case (v)
      UPD_FULL:                                       m = RM_FULL;
      UPD_FAST_A, UPD_FAST_B, UPD_FAST_C, UPD_FAST_D,
      UPD_FAST_E:                                     m = RM_FAST;
      UPD_HALF:                                       m = RM_HALF;
      UPD_GRAY:                                       m = RM_GRAY;
      UPD_POWER_ON, UPD_POWER_OFF:                    m = RM_NONE;
      default:                                        m = RM_OTHER;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/epcw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// epcw_cfg_regs
// Busy duration registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module epcw_cfg_regs
  import epcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BUSY_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // Always ready; each write is registered
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Update the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_us <= FULL_REFRESH_RST;
      cfg_r.fast_us <= FAST_REFRESH_RST;
      cfg_r.half_us <= HALF_REFRESH_RST;
      cfg_r.gray_us <= GRAY_REFRESH_RST;
      cfg_r.step_us <= POWER_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FULL_REFRESH: cfg_r.full_us <= cfg_data;
        CFG_FAST_REFRESH: cfg_r.fast_us <= cfg_data;
        CFG_HALF_REFRESH: cfg_r.half_us <= cfg_data;
        CFG_GRAY_REFRESH: cfg_r.gray_us <= cfg_data;
        CFG_POWER_STEP:   cfg_r.step_us <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/epcw_core.sv =====
// ----------------------------------------------------------------------------
// epcw_core
// Command decoder, argument gathering, window and address counter state.
// Computes the result of the staged word and updates state when it moves on.
// ----------------------------------------------------------------------------
module epcw_core
  import epcw_pkg::*;
#(
  parameter int PANEL_WIDTH  = 800,
  parameter int PANEL_HEIGHT = 480
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam logic [AXIS_W-1:0] X_END_RST = AXIS_W'(PANEL_WIDTH - 1);
  localparam logic [AXIS_W-1:0] Y_END_RST = AXIS_W'(PANEL_HEIGHT - 1);
  localparam logic [AXIS_W-1:0] X_LIMIT   = AXIS_W'(PANEL_WIDTH);
  localparam logic [AXIS_W-1:0] Y_LIMIT   = AXIS_W'(PANEL_HEIGHT);
  localparam logic [AXIS_W-1:0] X_STEP    = AXIS_W'(8);
  localparam logic [AXIS_W-1:0] Y_STEP    = AXIS_W'(1);

  logic [7:0]        cur_cmd_r,    cur_cmd_nxt;
  logic              cmd_valid_r,  cmd_valid_nxt;
  logic [2:0]        arg_count_r,  arg_count_nxt;
  logic [7:0]        arg0_r,       arg0_nxt;
  logic [7:0]        arg2_r,       arg2_nxt;
  logic [2:0]        entry_mode_r, entry_mode_nxt;
  logic              gate_flip_r,  gate_flip_nxt;
  logic [AXIS_W-1:0] wx_start_r,   wx_start_nxt;
  logic [AXIS_W-1:0] wx_end_r,     wx_end_nxt;
  logic [AXIS_W-1:0] wy_start_r,   wy_start_nxt;
  logic [AXIS_W-1:0] wy_end_r,     wy_end_nxt;
  logic [AXIS_W-1:0] cnt_x_r,      cnt_x_nxt;
  logic [AXIS_W-1:0] cnt_y_r,      cnt_y_nxt;
  logic [7:0]        upd_ctrl_r,   upd_ctrl_nxt;
  logic              lut_custom_r, lut_custom_nxt;
  logic              sleep_r,      sleep_nxt;

  logic [2:0]        arg_count_inc;
  logic [AXIS_W-1:0] pair_lo, pair_hi;
  logic [AXIS_W-1:0] x_step, y_step, adv_x, adv_y;
  logic              x_end, y_end, in_panel;
  refresh_mode_t     lut_mode, act_mode;
  result_t           res;

  // Odd argument bytes are the high halves and are taken straight from the word
  assign pair_lo = {item.value[AXIS_W-9:0], arg0_r};
  assign pair_hi = {item.value[AXIS_W-9:0], arg2_r};
  assign arg_count_inc = (arg_count_r != ARG_COUNT_MAX) ? arg_count_r + 3'd1 : arg_count_r;

  // Address counter advance inside the window, X compared by byte column
  assign x_step   = entry_mode_r[0] ? cnt_x_r + X_STEP : cnt_x_r - X_STEP;
  assign y_step   = entry_mode_r[1] ? cnt_y_r + Y_STEP : cnt_y_r - Y_STEP;
  assign x_end    = cnt_x_r[AXIS_W-1:3] == wx_end_r[AXIS_W-1:3];
  assign y_end    = cnt_y_r == wy_end_r;
  assign in_panel = (cnt_x_r < X_LIMIT) && (cnt_y_r < Y_LIMIT);

  always_comb begin
    adv_x = cnt_x_r;
    adv_y = cnt_y_r;
    if (!entry_mode_r[2]) begin
      if (!x_end) begin
        adv_x = x_step;
      end else begin
        adv_x = wx_start_r;
        adv_y = y_end ? wy_start_r : y_step;
      end
    end else begin
      if (!y_end) begin
        adv_y = y_step;
      end else begin
        adv_y = wy_start_r;
        adv_x = x_end ? wx_start_r : x_step;
      end
    end
  end

  // Refresh mode of a master activation; power-only codes report other
  always_comb begin
    lut_mode = lut_custom_r ? RM_GRAY : mode_lookup(upd_ctrl_r);
    act_mode = (lut_mode == RM_NONE) ? RM_OTHER : lut_mode;
  end

  // Decode the word, build the result and the next state
  always_comb begin
    cur_cmd_nxt    = cur_cmd_r;
    cmd_valid_nxt  = cmd_valid_r;
    arg_count_nxt  = arg_count_r;
    arg0_nxt       = arg0_r;
    arg2_nxt       = arg2_r;
    entry_mode_nxt = entry_mode_r;
    gate_flip_nxt  = gate_flip_r;
    wx_start_nxt   = wx_start_r;
    wx_end_nxt     = wx_end_r;
    wy_start_nxt   = wy_start_r;
    wy_end_nxt     = wy_end_r;
    cnt_x_nxt      = cnt_x_r;
    cnt_y_nxt      = cnt_y_r;
    upd_ctrl_nxt   = upd_ctrl_r;
    lut_custom_nxt = lut_custom_r;
    sleep_nxt      = sleep_r;
    res            = '0;
    res.memory_op    = MOP_NONE;
    res.refresh_mode = RM_NONE;

    if (item.cmd) begin
      cur_cmd_nxt   = item.value;
      cmd_valid_nxt = 1'b1;
      arg_count_nxt = '0;
      priority if (item.value == CMD_SW_RESET) begin
        entry_mode_nxt = ENTRY_MODE_RST;
        gate_flip_nxt  = 1'b0;
        wx_start_nxt   = '0;
        wx_end_nxt     = X_END_RST;
        wy_start_nxt   = '0;
        wy_end_nxt     = Y_END_RST;
        cnt_x_nxt      = '0;
        cnt_y_nxt      = '0;
        upd_ctrl_nxt   = '0;
        lut_custom_nxt = 1'b0;
        sleep_nxt      = 1'b0;
        res.busy_start = 1'b1;
        res.busy_us    = cfg.step_us;
      end else if (item.value == CMD_MASTER_ACT) begin
        res.busy_start = 1'b1;
        if (upd_ctrl_r[UPD_DISPLAY_BIT]) begin
          res.refresh_mode = act_mode;
          unique case (act_mode)
            RM_FAST: res.busy_us = cfg.fast_us;
            RM_HALF: res.busy_us = cfg.half_us;
            RM_GRAY: res.busy_us = cfg.gray_us;
            RM_NONE: res.busy_us = cfg.step_us;
            default: res.busy_us = cfg.full_us;
          endcase
          if (upd_ctrl_r[UPD_LUT_CLEAR_BIT]) begin
            lut_custom_nxt = 1'b0;
          end
        end else begin
          res.busy_us = cfg.step_us;
        end
      end else if (!known_code(item.value)) begin
        res.unknown_command = 1'b1;
      end
    end else begin
      arg_count_nxt = arg_count_inc;
      if (arg_count_r == 3'd0) arg0_nxt = item.value;
      if (arg_count_r == 3'd2) arg2_nxt = item.value;
      if (cmd_valid_r) begin
        unique case (cur_cmd_r)
          CMD_WRITE_BW, CMD_WRITE_RED: begin
            if (in_panel) begin
              res.memory_op = MOP_WRITE;
              res.plane     = cur_cmd_r == CMD_WRITE_RED;
              res.row       = cnt_y_r[8:0];
              res.column    = cnt_x_r[AXIS_W-1:3];
              res.data      = item.value;
            end
            cnt_x_nxt = adv_x;
            cnt_y_nxt = adv_y;
          end
          CMD_DATA_ENTRY: entry_mode_nxt = item.value[2:0];
          CMD_DRIVER_OUTPUT: begin
            if (arg_count_inc == 3'd3) gate_flip_nxt = |(item.value & 8'h05);
          end
          CMD_RAM_X_RANGE: begin
            if (arg_count_inc == 3'd2) wx_start_nxt = pair_lo;
            if (arg_count_inc == 3'd4) wx_end_nxt   = pair_hi;
          end
          CMD_RAM_Y_RANGE: begin
            if (arg_count_inc == 3'd2) wy_start_nxt = pair_lo;
            if (arg_count_inc == 3'd4) wy_end_nxt   = pair_hi;
          end
          CMD_RAM_X_COUNT: begin
            if (arg_count_inc == 3'd2) cnt_x_nxt = pair_lo;
          end
          CMD_RAM_Y_COUNT: begin
            if (arg_count_inc == 3'd2) cnt_y_nxt = pair_lo;
          end
          CMD_UPDATE_CTRL2: upd_ctrl_nxt   = item.value;
          CMD_WRITE_LUT:    lut_custom_nxt = 1'b1;
          CMD_FILL_BW, CMD_FILL_RED: begin
            res.memory_op  = MOP_FILL;
            res.plane      = cur_cmd_r == CMD_FILL_RED;
            res.data       = item.value[7] ? 8'hFF : 8'h00;
            res.busy_start = 1'b1;
            res.busy_us    = cfg.step_us;
          end
          CMD_DEEP_SLEEP: sleep_nxt = |item.value[1:0];
          default: ;
        endcase
      end
    end

    res.sleeping      = sleep_nxt;
    res.gate_reversed = gate_flip_nxt;
  end

  assign result = res;

  // Commit control state when the word moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cmd_r    <= '0;
      cmd_valid_r  <= 1'b0;
      arg_count_r  <= '0;
      entry_mode_r <= ENTRY_MODE_RST;
      gate_flip_r  <= 1'b0;
      wx_start_r   <= '0;
      wx_end_r     <= X_END_RST;
      wy_start_r   <= '0;
      wy_end_r     <= Y_END_RST;
      cnt_x_r      <= '0;
      cnt_y_r      <= '0;
      upd_ctrl_r   <= '0;
      lut_custom_r <= 1'b0;
      sleep_r      <= 1'b0;
    end else if (step) begin
      cur_cmd_r    <= cur_cmd_nxt;
      cmd_valid_r  <= cmd_valid_nxt;
      arg_count_r  <= arg_count_nxt;
      entry_mode_r <= entry_mode_nxt;
      gate_flip_r  <= gate_flip_nxt;
      wx_start_r   <= wx_start_nxt;
      wx_end_r     <= wx_end_nxt;
      wy_start_r   <= wy_start_nxt;
      wy_end_r     <= wy_end_nxt;
      cnt_x_r      <= cnt_x_nxt;
      cnt_y_r      <= cnt_y_nxt;
      upd_ctrl_r   <= upd_ctrl_nxt;
      lut_custom_r <= lut_custom_nxt;
      sleep_r      <= sleep_nxt;
    end
  end

  // Argument bytes are always written before they are read
  always_ff @(posedge clk) begin
    if (step) begin
      arg0_r <= arg0_nxt;
      arg2_r <= arg2_nxt;
    end
  end

endmodule

// ===== hw/rtl/epaper_command_ram_window_writer.sv =====
// The result register is loaded from the core when it is free or being emptied.
// Throughput: one word per cycle while out_tready is high; the input register
// and the result register each hold one word, so one word is taken while a
// result waits to be taken. The rate is set by the single decode and counter
// step between the two. Reset (rst_n low, synchronous) empties both registers,
// restores the window, counter and flags and loads the default busy durations.
// ----------------------------------------------------------------------------
// epaper_command_ram_window_writer
// Top level: input register, command and window core, result register and
// the configuration register file.
// ----------------------------------------------------------------------------
module epaper_command_ram_window_writer
  import epcw_pkg::*;
#(
  parameter int PANEL_WIDTH  = 800,
  parameter int PANEL_HEIGHT = 480
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // value
  input  logic [0:0]             in_tuser,   // cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // memory_op[1:0], plane[2], row[11:3], column[18:12], data[26:19],
  // refresh_mode[29:27], busy_start[30], busy_us[54:31],
  // unknown_command[55], sleeping[56], gate_reversed[57], zeros above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [BUSY_W-1:0]      cfg_data
);

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t out_result_r;
  result_t core_result;
  cfg_t    cfg;
  logic    advance;

  // Move the staged word on when the result register is free or being emptied
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  epcw_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  epcw_core #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (core_result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.cmd   <= in_tuser[0];
      item_r.value <= in_tdata;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result_r <= core_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_result_r};

`ifndef ASSERT_OFF
  a_fill_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_result_r.memory_op == MOP_FILL |->
      out_result_r.busy_start && out_result_r.row == '0 && out_result_r.column == '0)
    else $error("plane fill without busy start or with a non-zero address");

  a_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_result_r.unknown_command |->
      out_result_r.memory_op == MOP_NONE && !out_result_r.busy_start)
    else $error("unknown command word carries a memory or busy action");

  a_refresh_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_result_r.refresh_mode != RM_NONE |-> out_result_r.busy_start)
    else $error("refresh mode reported without a busy period");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the result register is empty");

  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("staged word lost on its way to the result register");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the e-paper command and RAM window writer: drives
// command and data bytes on the input stream, keeps its own model of the
// command decoder, window registers and address counter, and compares every
// result word field by field against the model's prediction or a fixed expected word.
// ----------------------------------------------------------------------------
module tb_top
  import epcw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PANEL_W         = 800;
  localparam int PANEL_H         = 480;
  localparam int NUM_REGS        = int'(CFG_POWER_STEP) + 1;
  localparam int ARGS_KEPT       = 4;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SETTLE_CYCLES   = 4;

  localparam logic [9:0] X_STEP    = 10'd8;
  localparam logic [9:0] Y_STEP    = 10'd1;
  localparam logic [7:0] GATE_MASK = 8'h05;

  // Commands that only take argument bytes and change nothing we model
  localparam logic [7:0] PLAIN_CODES [11] = '{
    CMD_GATE_VOLTAGE, CMD_SOURCE_VOLTAGE, CMD_BOOSTER, CMD_TEMP_SENSOR,
    CMD_TEMP_WRITE, CMD_UPDATE_CTRL1, CMD_VCOM, CMD_BORDER, CMD_AUX_A,
    CMD_AUX_B, CMD_AUX_C};
  localparam logic [7:0] WINDOW_CODES [4] = '{
    CMD_RAM_X_RANGE, CMD_RAM_Y_RANGE, CMD_RAM_X_COUNT, CMD_RAM_Y_COUNT};
  localparam logic [7:0] UPD_CODES [10] = '{
    UPD_FULL, UPD_FAST_A, UPD_FAST_B, UPD_FAST_C, UPD_FAST_D, UPD_FAST_E,
    UPD_HALF, UPD_GRAY, UPD_POWER_ON, UPD_POWER_OFF};

  typedef struct {
    logic       cmd;
    logic [7:0] value;
    bit         fixed;
    result_t    res;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;   // value
  logic [0:0]             in_tuser   = '0;   // cmd
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // memory_op, plane, row, column, data, refresh_mode, busy_start, busy_us,
  // unknown_command, sleeping, gate_reversed, zeros above
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [BUSY_W-1:0]      cfg_data   = '0;

  // Model of the block: busy durations, decoder and window state
  logic [BUSY_W-1:0] dur [NUM_REGS];
  logic [BUSY_W-1:0] next_dur [NUM_REGS];
  logic [7:0]        cur_cmd;
  logic              cmd_seen;
  logic [2:0]        arg_n;
  logic [7:0]        args [ARGS_KEPT];
  logic [2:0]        entry;
  logic              gflip;
  logic [9:0]        wxs, wxe, wys, wye, cx, cy;
  logic [7:0]        upd;
  logic              lut, slp;

  result_t expected_words [$];
  int      mismatches    = 0;
  int      words_sent    = 0;
  int      words_checked = 0;
  int      src_gap_pct   = 0;
  int      sink_idle_pct = 0;
  bit      hold_req      = 1'b0;

  always #6 clk = ~clk;

  epaper_command_ram_window_writer #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- model

  // Window, counter, mode and flags as after power-up or software reset
  function automatic void restore_panel_regs();
    entry = ENTRY_MODE_RST;
    gflip = 1'b0;
    wxs   = '0;
    wxe   = 10'(PANEL_W - 1);
    wys   = '0;
    wye   = 10'(PANEL_H - 1);
    cx    = '0;
    cy    = '0;
    upd   = '0;
    lut   = 1'b0;
    slp   = 1'b0;
  endfunction

  // One counter step, modulo 1024
  function automatic logic [9:0] axis_step(input logic [9:0] v, input logic up,
                                           input logic [9:0] d);
    return up ? v + d : v - d;
  endfunction

  // Ten-bit value from a low/high argument byte pair
  function automatic logic [9:0] arg_pair(input int lo);
    return {args[lo + 1][1:0], args[lo]};
  endfunction

  // Apply one byte to the model and return the result word it gives
  function automatic result_t decode_word(input logic is_cmd, input logic [7:0] b);
    result_t r;
    logic    x_end, y_end;
    r = '0;
    if (is_cmd) begin
      cur_cmd  = b;
      cmd_seen = 1'b1;
      arg_n    = '0;
      case (b)
        CMD_SW_RESET: begin
          restore_panel_regs();
          r.busy_start = 1'b1;
          r.busy_us    = dur[CFG_POWER_STEP];
        end
        CMD_MASTER_ACT: begin
          r.busy_start = 1'b1;
          if (!upd[UPD_DISPLAY_BIT]) begin
            r.busy_us = dur[CFG_POWER_STEP];
          end else begin
            // custom waveform forces grey; unlisted and power-only codes are other
            if (lut) begin
              r.refresh_mode = RM_GRAY;
            end else begin
              case (upd)
                UPD_FULL:                 r.refresh_mode = RM_FULL;
                UPD_FAST_A, UPD_FAST_B, UPD_FAST_C, UPD_FAST_D,
                UPD_FAST_E:               r.refresh_mode = RM_FAST;
                UPD_HALF:                 r.refresh_mode = RM_HALF;
                UPD_GRAY:                 r.refresh_mode = RM_GRAY;
                default:                  r.refresh_mode = RM_OTHER;
              endcase
            end
            case (r.refresh_mode)
              RM_FAST: r.busy_us = dur[CFG_FAST_REFRESH];
              RM_HALF: r.busy_us = dur[CFG_HALF_REFRESH];
              RM_GRAY: r.busy_us = dur[CFG_GRAY_REFRESH];
              default: r.busy_us = dur[CFG_FULL_REFRESH];
            endcase
            if (upd[UPD_LUT_CLEAR_BIT]) lut = 1'b0;
          end
        end
        CMD_DRIVER_OUTPUT, CMD_GATE_VOLTAGE, CMD_SOURCE_VOLTAGE, CMD_BOOSTER,
        CMD_DEEP_SLEEP, CMD_DATA_ENTRY, CMD_TEMP_SENSOR, CMD_TEMP_WRITE,
        CMD_UPDATE_CTRL1, CMD_UPDATE_CTRL2, CMD_WRITE_BW, CMD_WRITE_RED,
        CMD_VCOM, CMD_WRITE_LUT, CMD_BORDER, CMD_RAM_X_RANGE, CMD_RAM_Y_RANGE,
        CMD_FILL_BW, CMD_FILL_RED, CMD_RAM_X_COUNT, CMD_RAM_Y_COUNT,
        CMD_AUX_A, CMD_AUX_B, CMD_AUX_C: ;
        default: r.unknown_command = 1'b1;
      endcase
    end else begin
      // keep the first four argument bytes, count saturates
      if (arg_n < ARGS_KEPT) args[arg_n[1:0]] = b;
      if (arg_n < ARG_COUNT_MAX) arg_n = arg_n + 3'd1;
      if (cmd_seen) begin
        case (cur_cmd)
          CMD_WRITE_BW, CMD_WRITE_RED: begin
            if (cx < PANEL_W && cy < PANEL_H) begin
              r.memory_op = MOP_WRITE;
              r.plane     = (cur_cmd == CMD_WRITE_RED);
              r.row       = cy[8:0];
              r.column    = cx[9:3];
              r.data      = b;
            end
            // advance along the fast axis, reload at the end of the window
            x_end = (cx[9:3] == wxe[9:3]);
            y_end = (cy == wye);
            if (!entry[2]) begin
              if (!x_end) begin
                cx = axis_step(cx, entry[0], X_STEP);
              end else begin
                cx = wxs;
                cy = y_end ? wys : axis_step(cy, entry[1], Y_STEP);
              end
            end else begin
              if (!y_end) begin
                cy = axis_step(cy, entry[1], Y_STEP);
              end else begin
                cy = wys;
                cx = x_end ? wxs : axis_step(cx, entry[0], X_STEP);
              end
            end
          end
          CMD_DATA_ENTRY:    entry = b[2:0];
          CMD_DRIVER_OUTPUT: if (arg_n == 3'd3) gflip = |(b & GATE_MASK);
          CMD_RAM_X_RANGE: begin
            if (arg_n == 3'd2) wxs = arg_pair(0);
            if (arg_n == 3'd4) wxe = arg_pair(2);
          end
          CMD_RAM_Y_RANGE: begin
            if (arg_n == 3'd2) wys = arg_pair(0);
            if (arg_n == 3'd4) wye = arg_pair(2);
          end
          CMD_RAM_X_COUNT:  if (arg_n == 3'd2) cx = arg_pair(0);
          CMD_RAM_Y_COUNT:  if (arg_n == 3'd2) cy = arg_pair(0);
          CMD_UPDATE_CTRL2: upd = b;
          CMD_WRITE_LUT:    lut = 1'b1;
          CMD_FILL_BW, CMD_FILL_RED: begin
            r.memory_op  = MOP_FILL;
            r.plane      = (cur_cmd == CMD_FILL_RED);
            r.data       = b[7] ? 8'hFF : 8'h00;
            r.busy_start = 1'b1;
            r.busy_us    = dur[CFG_POWER_STEP];
          end
          CMD_DEEP_SLEEP:   slp = |b[1:0];
          default: ;
        endcase
      end
    end
    r.sleeping      = slp;
    r.gate_reversed = gflip;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one word, wait for it to be taken, then log its expected result
  task automatic put_word(input logic c, input logic [7:0] v, input bit fixed,
                          input result_t fixed_res);
    result_t r;
    if ($urandom_range(0, 99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    r = decode_word(c, v);
    expected_words.push_back(fixed ? fixed_res : r);
    words_sent++;
  endtask

  task automatic put_cmd(input logic [7:0] b);
    put_word(1'b1, b, 1'b0, '0);
  endtask

  task automatic put_data(input logic [7:0] b);
    put_word(1'b0, b, 1'b0, '0);
  endtask

  // Low byte, then high byte with junk above the two address bits
  task automatic put_pair(input logic [9:0] v);
    put_data(v[7:0]);
    put_data({6'($urandom), v[9:8]});
  endtask

  task automatic set_window(input logic [7:0] code, input logic [9:0] s,
                            input logic [9:0] e);
    put_cmd(code);
    put_pair(s);
    put_pair(e);
  endtask

  // Write all durations from next_dur, optionally poking the unused indexes
  task automatic load_regs(input bit spare);
    int i, top;
    top = spare ? (1 << CFG_IDX_W) : NUM_REGS;
    for (i = 0; i < top; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= (i < NUM_REGS) ? next_dur[i] : BUSY_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
      if (i < NUM_REGS) dur[i] = next_dur[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random, mostly well-formed command sequence
  task automatic one_sequence();
    int         kind, n;
    logic [9:0] xlo, xhi, ylo, yhi;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // pixel burst: entry mode, window, counter, then RAM bytes
      if ($urandom_range(0, 3) != 0) begin
        put_cmd(CMD_DATA_ENTRY);
        put_data(8'($urandom));
      end
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 5) == 0) begin
          xlo = 10'($urandom);
          xhi = 10'($urandom);
          ylo = 10'($urandom);
          yhi = 10'($urandom);
        end else begin
          xlo = 10'($urandom_range(0, 95) * 8 + $urandom_range(0, 7));
          xhi = xlo + 10'($urandom_range(0, 4) * 8);
          ylo = 10'($urandom_range(0, 474));
          yhi = ylo + 10'($urandom_range(0, 5));
        end
        // start where the walk begins, end where it wraps
        if (entry[0]) set_window(CMD_RAM_X_RANGE, xlo, xhi);
        else          set_window(CMD_RAM_X_RANGE, xhi, xlo);
        if (entry[1]) set_window(CMD_RAM_Y_RANGE, ylo, yhi);
        else          set_window(CMD_RAM_Y_RANGE, yhi, ylo);
        put_cmd(CMD_RAM_X_COUNT);
        if ($urandom_range(0, 5) == 0) put_pair(10'($urandom));
        else                           put_pair(wxs);
        put_cmd(CMD_RAM_Y_COUNT);
        if ($urandom_range(0, 5) == 0) put_pair(10'($urandom));
        else                           put_pair(wys);
      end
      put_cmd($urandom_range(0, 1) ? CMD_WRITE_RED : CMD_WRITE_BW);
      repeat ($urandom_range(1, 30)) put_data(8'($urandom));
    end else if (kind < 50) begin
      // update control and activation, sometimes after a custom LUT
      if ($urandom_range(0, 3) == 0) begin
        put_cmd(CMD_WRITE_LUT);
        repeat ($urandom_range(1, 3)) put_data(8'($urandom));
      end
      put_cmd(CMD_UPDATE_CTRL2);
      n = $urandom_range(1, 2);
      repeat (n) begin
        if ($urandom_range(0, 1)) put_data(UPD_CODES[$urandom_range(0, 9)]);
        else                      put_data(8'($urandom));
      end
      put_cmd(CMD_MASTER_ACT);
    end else if (kind < 58) begin
      put_cmd($urandom_range(0, 1) ? CMD_FILL_RED : CMD_FILL_BW);
      repeat ($urandom_range(1, 2)) put_data(8'($urandom));
    end else if (kind < 64) begin
      put_cmd(CMD_DEEP_SLEEP);
      put_data(8'($urandom));
    end else if (kind < 70) begin
      // driver output: third byte carries gate reversal, extra bytes saturate
      put_cmd(CMD_DRIVER_OUTPUT);
      repeat ($urandom_range(2, 9)) put_data(8'($urandom));
    end else if (kind < 74) begin
      put_cmd(CMD_SW_RESET);
    end else if (kind < 82) begin
      put_cmd(PLAIN_CODES[$urandom_range(0, 10)]);
      repeat ($urandom_range(0, 3)) put_data(8'($urandom));
    end else if (kind < 90) begin
      // window and counter commands with short, full or overlong argument runs
      put_cmd(WINDOW_CODES[$urandom_range(0, 3)]);
      repeat ($urandom_range(0, 9)) put_data(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) put_word(1'($urandom), 8'($urandom), 1'b0, '0);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) one_sequence();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %0h, want %0h",
                                words_checked, name, got, want));
  endtask

  // Compare each result word taken against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        got  = result_t'(out_tdata[RESULT_W-1:0]);
        want = expected_words.pop_front();
        check_field("memory_op",       32'(got.memory_op),       32'(want.memory_op));
        check_field("plane",           32'(got.plane),           32'(want.plane));
        check_field("row",             32'(got.row),             32'(want.row));
        check_field("column",          32'(got.column),          32'(want.column));
        check_field("data",            32'(got.data),            32'(want.data));
        check_field("refresh_mode",    32'(got.refresh_mode),    32'(want.refresh_mode));
        check_field("busy_start",      32'(got.busy_start),      32'(want.busy_start));
        check_field("busy_us",         32'(got.busy_us),         32'(want.busy_us));
        check_field("unknown_command", 32'(got.unknown_command), 32'(want.unknown_command));
        check_field("sleeping",        32'(got.sleeping),        32'(want.sleeping));
        check_field("gate_reversed",   32'(got.gate_reversed),   32'(want.gate_reversed));
        check_field("padding",         32'(out_tdata[OUT_TDATA_W-1:RESULT_W]), 32'd0);
        words_checked++;
      end
    end
  end

  // Result side: random stalls, and a long hold-off on request
  initial begin : result_sink
    int k;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        for (k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge clk);
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #5_000_000;
    $display("FAIL epaper_command_ram_window_writer");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    result_t  r;
    dir_row_t dir_rows [$];
    int       i;

    // model at reset
    dur[CFG_FULL_REFRESH] = FULL_REFRESH_RST;
    dur[CFG_FAST_REFRESH] = FAST_REFRESH_RST;
    dur[CFG_HALF_REFRESH] = HALF_REFRESH_RST;
    dur[CFG_GRAY_REFRESH] = GRAY_REFRESH_RST;
    dur[CFG_POWER_STEP]   = POWER_STEP_RST;
    cur_cmd  = '0;
    cmd_seen = 1'b0;
    arg_n    = '0;
    for (i = 0; i < ARGS_KEPT; i++) args[i] = '0;
    restore_panel_regs();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words; fixed expectations where the answer is plain
    r = '0;
    dir_rows.push_back('{1'b0, 8'hA5, 1'b1, r});               // data before any command
    r = '0; r.unknown_command = 1'b1;
    dir_rows.push_back('{1'b1, 8'h00, 1'b1, r});
    dir_rows.push_back('{1'b1, 8'hFF, 1'b1, r});
    r = '0; r.busy_start = 1'b1; r.busy_us = POWER_STEP_RST;
    dir_rows.push_back('{1'b1, CMD_MASTER_ACT, 1'b1, r});      // no display bit
    dir_rows.push_back('{1'b1, CMD_WRITE_BW, 1'b0, '0});
    r = '0; r.memory_op = MOP_WRITE;
    dir_rows.push_back('{1'b0, 8'h00, 1'b1, r});
    r.column = 7'd1; r.data = 8'hFF;
    dir_rows.push_back('{1'b0, 8'hFF, 1'b1, r});
    dir_rows.push_back('{1'b1, CMD_FILL_RED, 1'b0, '0});
    r = '0; r.memory_op = MOP_FILL; r.plane = 1'b1; r.data = 8'hFF;
    r.busy_start = 1'b1; r.busy_us = POWER_STEP_RST;
    dir_rows.push_back('{1'b0, 8'h80, 1'b1, r});
    r.data = 8'h00;
    dir_rows.push_back('{1'b0, 8'h7F, 1'b1, r});
    // custom LUT forces grey, and the clear bit drops it
    dir_rows.push_back('{1'b1, CMD_WRITE_LUT, 1'b0, '0});
    dir_rows.push_back('{1'b0, 8'h00, 1'b0, '0});
    dir_rows.push_back('{1'b1, CMD_UPDATE_CTRL2, 1'b0, '0});
    dir_rows.push_back('{1'b0, UPD_FAST_A, 1'b0, '0});
    r = '0; r.refresh_mode = RM_GRAY; r.busy_start = 1'b1; r.busy_us = GRAY_REFRESH_RST;
    dir_rows.push_back('{1'b1, CMD_MASTER_ACT, 1'b1, r});
    // display bit alone is not a listed mode
    dir_rows.push_back('{1'b1, CMD_UPDATE_CTRL2, 1'b0, '0});
    dir_rows.push_back('{1'b0, 8'h04, 1'b0, '0});
    r = '0; r.refresh_mode = RM_OTHER; r.busy_start = 1'b1; r.busy_us = FULL_REFRESH_RST;
    dir_rows.push_back('{1'b1, CMD_MASTER_ACT, 1'b1, r});
    // counter past the panel edge: nothing written, counter still moves
    dir_rows.push_back('{1'b1, CMD_RAM_X_COUNT, 1'b0, '0});
    dir_rows.push_back('{1'b0, 8'hFF, 1'b0, '0});
    dir_rows.push_back('{1'b0, 8'h03, 1'b0, '0});
    dir_rows.push_back('{1'b1, CMD_WRITE_RED, 1'b0, '0});
    r = '0;
    dir_rows.push_back('{1'b0, 8'h5A, 1'b1, r});
    dir_rows.push_back('{1'b1, CMD_DEEP_SLEEP, 1'b0, '0});
    r = '0; r.sleeping = 1'b1;
    dir_rows.push_back('{1'b0, 8'h03, 1'b1, r});
    r = '0; r.busy_start = 1'b1; r.busy_us = POWER_STEP_RST;
    dir_rows.push_back('{1'b1, CMD_SW_RESET, 1'b1, r});

    src_gap_pct   = 20;
    sink_idle_pct = 5;
    foreach (dir_rows[j]) put_word(dir_rows[j].cmd, dir_rows[j].value,
                                   dir_rows[j].fixed, dir_rows[j].res);
    drain();

    // Random durations, unused indexes poked, long result hold-off
    for (i = 0; i < NUM_REGS; i++) next_dur[i] = BUSY_W'($urandom);
    load_regs(1'b1);
    src_gap_pct   = 25;
    sink_idle_pct = 6;
    hold_req      = 1'b1;
    run_random(500);
    drain();

    // All durations zero
    for (i = 0; i < NUM_REGS; i++) next_dur[i] = '0;
    load_regs(1'b0);
    src_gap_pct   = 5;
    sink_idle_pct = 20;
    hold_req      = 1'b1;
    run_random(300);
    drain();

    // All durations at full scale
    for (i = 0; i < NUM_REGS; i++) next_dur[i] = '1;
    load_regs(1'b0);
    src_gap_pct   = 15;
    sink_idle_pct = 10;
    run_random(250);
    drain();

    // Random durations again, no idling to the end
    for (i = 0; i < NUM_REGS; i++) next_dur[i] = BUSY_W'($urandom);
    load_regs(1'b0);
    src_gap_pct   = 0;
    sink_idle_pct = 0;
    run_random(300);
    drain();

    if (mismatches == 0) begin
      $display("PASS epaper_command_ram_window_writer");
    end else begin
      $display("FAIL epaper_command_ram_window_writer");
    end
    $finish;
  end

endmodule

// ===== epaper_command_ram_window_writer.f =====
hw/rtl/epcw_pkg.sv
hw/rtl/epcw_cfg_regs.sv
hw/rtl/epcw_core.sv
hw/rtl/epaper_command_ram_window_writer.sv
tb/tb_top.sv
